>>> rtl/mpa_pkg.sv
// ----------------------------------------------------------------------------
// mpa_pkg
// shared constants and control structs of the masked probability argmax block
// ----------------------------------------------------------------------------
package mpa_pkg;

  // default configuration
  localparam int unsigned NumQubitsDef = 10;
  localparam int unsigned FracBitsDef  = 32;

  // run tag kept beside every accumulator; tag zero marks a cleared entry
  localparam int unsigned EpochW = 8;

  // apb
  localparam int unsigned PaddrW = 2;
  localparam int unsigned PdataW = 32;

  // update stage status toward the sequencer
  typedef struct packed {
    logic fire;   // an item is in the update stage
    logic last;   // that item closes the run
  } stage_stat_t;

  // output buffer occupancy
  typedef struct packed {
    logic out_valid;
    logic skid_valid;
  } buf_stat_t;

endpackage

>>> rtl/mpa_acc_mem.sv
// ----------------------------------------------------------------------------
// mpa_acc_mem
// accumulator memory, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module mpa_acc_mem #(
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 42
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  localparam int unsigned Depth = 1 << AddrW;

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read-first: a read at the address written in the same cycle sees old data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mpa_update.sv
// ----------------------------------------------------------------------------
// mpa_update
// read-modify-write of one accumulator per item, forwarding, running argmax
// ----------------------------------------------------------------------------
module mpa_update #(
  parameter int unsigned NumQubits = mpa_pkg::NumQubitsDef,
  parameter int unsigned FracBits  = mpa_pkg::FracBitsDef
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_fire_i,
  input  logic [NumQubits-1:0]                        in_index_i,
  input  logic [FracBits:0]                           in_prob_i,
  input  logic                                        in_last_i,
  input  logic [NumQubits-1:0]                        mask_i,
  input  logic [mpa_pkg::EpochW-1:0]                  epoch_i,
  output logic [NumQubits-1:0]                        rd_addr_o,
  input  logic [mpa_pkg::EpochW+FracBits+1:0]         rd_data_i,
  output logic                                        wr_en_o,
  output logic [NumQubits-1:0]                        wr_addr_o,
  output logic [mpa_pkg::EpochW+FracBits+1:0]         wr_data_o,
  output mpa_pkg::stage_stat_t                        stage_o,
  output logic [NumQubits-1:0]                        res_state_o,
  output logic [FracBits+1:0]                         res_prob_o
);

  localparam int unsigned AccW  = FracBits + 2;
  localparam int unsigned ProbW = FracBits + 1;
  localparam int unsigned SumW  = AccW + 1;
  localparam int unsigned MemW  = mpa_pkg::EpochW + AccW;

  logic                 v1_q;
  logic                 last1_q;
  logic [NumQubits-1:0] state1_q;
  logic [ProbW-1:0]     prob1_q;

  logic                 fwd_v_q;
  logic [NumQubits-1:0] fwd_state_q;
  logic [MemW-1:0]      fwd_word_q;

  logic [NumQubits-1:0] best_state_q, best_state_d;
  logic [AccW-1:0]      best_val_q, best_val_d;

  logic [MemW-1:0]      cur_word;
  logic [AccW-1:0]      base;
  logic [SumW-1:0]      sum_wide;
  logic [AccW-1:0]      sum_sat;
  logic                 take;

  assign rd_addr_o = in_index_i & mask_i;

  always_comb begin
    // last write went out in the cycle the read was issued: memory data is stale
    if (fwd_v_q && (fwd_state_q == state1_q)) begin
      cur_word = fwd_word_q;
    end else begin
      cur_word = rd_data_i;
    end
    // entry tagged with another run counts as zero
    if (cur_word[MemW-1 -: mpa_pkg::EpochW] == epoch_i) begin
      base = cur_word[AccW-1:0];
    end else begin
      base = '0;
    end
    sum_wide = {1'b0, base} + SumW'(prob1_q);
    sum_sat  = sum_wide[AccW] ? {AccW{1'b1}} : sum_wide[AccW-1:0];
    take     = sum_sat > best_val_q;
    best_state_d = take ? state1_q : best_state_q;
    best_val_d   = take ? sum_sat  : best_val_q;
  end

  assign wr_en_o      = v1_q;
  assign wr_addr_o    = state1_q;
  assign wr_data_o    = {epoch_i, sum_sat};
  assign stage_o.fire = v1_q;
  assign stage_o.last = last1_q;
  assign res_state_o  = best_state_d;
  assign res_prob_o   = best_val_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q         <= 1'b0;
      last1_q      <= 1'b0;
      fwd_v_q      <= 1'b0;
      best_state_q <= '0;
      best_val_q   <= '0;
    end else begin
      v1_q    <= in_fire_i;
      last1_q <= in_fire_i & in_last_i;
      fwd_v_q <= v1_q;
      if (v1_q) begin
        if (last1_q) begin
          best_state_q <= '0;
          best_val_q   <= '0;
        end else begin
          best_state_q <= best_state_d;
          best_val_q   <= best_val_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      state1_q <= rd_addr_o;
      prob1_q  <= in_prob_i;
    end
    fwd_state_q <= state1_q;
    fwd_word_q  <= wr_data_o;
  end

endmodule

>>> rtl/mpa_out_buf.sv
// ----------------------------------------------------------------------------
// mpa_out_buf
// result output register with one skid entry
// ----------------------------------------------------------------------------
module mpa_out_buf #(
  parameter int unsigned DataW = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [DataW-1:0]   in_data_i,
  input  logic               tready_i,
  output logic               tvalid_o,
  output logic [DataW-1:0]   tdata_o,
  output mpa_pkg::buf_stat_t stat_o
);

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q, out_data_d;
  logic             skid_valid_q, skid_valid_d;
  logic [DataW-1:0] skid_data_q, skid_data_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || tready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_valid_i;
        out_data_d  = in_data_i;
      end
    end else if (in_valid_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign tvalid_o          = out_valid_q;
  assign tdata_o           = out_data_q;
  assign stat_o.out_valid  = out_valid_q;
  assign stat_o.skid_valid = skid_valid_q;

endmodule

>>> rtl/masked_probability_argmax_top.sv
// ----------------------------------------------------------------------------
// masked_probability_argmax_top
// masked histogram of basis-state probabilities with a running argmax
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  --------  ---  ---------------------  ---------------------------------------
//  s_axis    in   tvalid/tready          tdata: basis_index, probability
//                                        tlast: last_item
//  m_axis    out  tvalid/tready          tdata: best_state, best_probability
//  apb       in   psel/penable/pready    subset_mask at byte address 0
//
//  one input beat per cycle sustained; each beat is a read of the accumulator
//  memory in its accept cycle and an add, saturate and write back in the next,
//  with the just-written entry forwarded to the following beat
//  after a last beat, s_axis stalls while that beat is written back if a result still
//  waits on m_axis; with both the output register and skid entry full it stalls until
//  m_axis drains
//  after reset, and after every 255th run, a clearing pass writes every one of the
//  2**NUM_QUBITS entries; s_axis is held off meanwhile, apb stays open
//  runs in between are cleared by a per-entry run tag, not by a sweep
//
// ----------------------------------------------------------------------------
module masked_probability_argmax_top #(
  parameter int unsigned NUM_QUBITS = mpa_pkg::NumQubitsDef,
  parameter int unsigned FRAC_BITS  = mpa_pkg::FracBitsDef,
  // derived widths
  parameter int unsigned IN_TDATA_W  = ((NUM_QUBITS + FRAC_BITS + 1 + 7) / 8) * 8,
  parameter int unsigned OUT_TDATA_W = ((NUM_QUBITS + FRAC_BITS + 2 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_TDATA_W-1:0]         s_axis_tdata,  // basis_index, probability
  input  logic                          s_axis_tlast,  // last_item
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_TDATA_W-1:0]        m_axis_tdata,  // best_state, best_probability
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpa_pkg::PaddrW-1:0]    paddr,
  input  logic [mpa_pkg::PdataW-1:0]    pwdata,
  output logic [mpa_pkg::PdataW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned AccW   = FRAC_BITS + 2;
  localparam int unsigned ProbW  = FRAC_BITS + 1;
  localparam int unsigned EpochW = mpa_pkg::EpochW;
  localparam int unsigned MemW   = EpochW + AccW;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } seq_state_e;

  seq_state_e                seq_q, seq_d;
  logic [NUM_QUBITS-1:0]     clr_cnt_q, clr_cnt_d;
  logic [EpochW-1:0]         epoch_q, epoch_d;
  logic [NUM_QUBITS-1:0]     mask_q;

  logic                      in_fire;
  logic                      wrap;
  logic                      run_end;
  mpa_pkg::stage_stat_t      stage;
  mpa_pkg::buf_stat_t        bstat;

  logic [NUM_QUBITS-1:0]     rd_addr;
  logic [MemW-1:0]           rd_data;
  logic                      upd_we;
  logic [NUM_QUBITS-1:0]     upd_waddr;
  logic [MemW-1:0]           upd_wdata;
  logic                      mem_we;
  logic [NUM_QUBITS-1:0]     mem_waddr;
  logic [MemW-1:0]           mem_wdata;

  logic [NUM_QUBITS-1:0]     res_state;
  logic [AccW-1:0]           res_prob;

  // ---------------------------------------------------------------------------
  // configuration register, single word so every address maps to it
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = mpa_pkg::PdataW'(mask_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      mask_q <= pwdata[NUM_QUBITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // flow control
  // ---------------------------------------------------------------------------
  // tag wraps: the run that ends now is the last before a full clearing pass
  assign wrap    = (epoch_q == {EpochW{1'b1}});
  assign run_end = stage.fire && stage.last;

  // hold off input while clearing or with the skid entry full, and the beat after a run
  // end if its result may find no free slot or if the run end starts a clearing pass
  assign s_axis_tready = (seq_q == ST_RUN) && !bstat.skid_valid &&
                         !(run_end && (bstat.out_valid || wrap));
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // clear / run tag sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    seq_d     = seq_q;
    clr_cnt_d = clr_cnt_q;
    epoch_d   = epoch_q;
    unique case (seq_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == {NUM_QUBITS{1'b1}}) begin
          seq_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_end) begin
          if (wrap) begin
            // tag zero is only ever written by the sweep, runs use 1 and up
            epoch_d   = EpochW'(1);
            seq_d     = ST_CLEAR;
            clr_cnt_d = '0;
          end else begin
            epoch_d = epoch_q + 1'b1;
          end
        end
      end
      default: begin
        seq_d     = ST_CLEAR;
        clr_cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= ST_CLEAR;
      clr_cnt_q <= '0;
      epoch_q   <= EpochW'(1);
    end else begin
      seq_q     <= seq_d;
      clr_cnt_q <= clr_cnt_d;
      epoch_q   <= epoch_d;
    end
  end

  // sweep owns the write port while clearing; the update stage is empty then
  always_comb begin
    if (seq_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = upd_we;
      mem_waddr = upd_waddr;
      mem_wdata = upd_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------
  mpa_acc_mem #(
    .AddrW (NUM_QUBITS),
    .DataW (MemW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  mpa_update #(
    .NumQubits (NUM_QUBITS),
    .FracBits  (FRAC_BITS)
  ) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .in_index_i  (s_axis_tdata[NUM_QUBITS-1:0]),
    .in_prob_i   (s_axis_tdata[NUM_QUBITS +: ProbW]),
    .in_last_i   (s_axis_tlast),
    .mask_i      (mask_q),
    .epoch_i     (epoch_q),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (upd_we),
    .wr_addr_o   (upd_waddr),
    .wr_data_o   (upd_wdata),
    .stage_o     (stage),
    .res_state_o (res_state),
    .res_prob_o  (res_prob)
  );

  mpa_out_buf #(
    .DataW (OUT_TDATA_W)
  ) u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (run_end),
    .in_data_i  (OUT_TDATA_W'({res_prob, res_state})),
    .tready_i   (m_axis_tready),
    .tvalid_o   (m_axis_tvalid),
    .tdata_o    (m_axis_tdata),
    .stat_o     (bstat)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // skid entry only fills behind a held output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.skid_valid |-> bstat.out_valid)
    else $error("skid entry valid with empty output register");

  // a run end never meets a full skid entry, else a result would be dropped
  a_run_end_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_end |-> !bstat.skid_valid)
    else $error("run end with no room for its result");

  // no beat accepted while the sweep owns the memory
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == ST_CLEAR) |-> !in_fire)
    else $error("input beat accepted during clearing pass");

  // tag zero is reserved for swept entries
  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("run tag reached reserved value");

  // the run that exhausts the tags is followed by a sweep
  a_wrap_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == ST_RUN) && run_end && wrap |=> (seq_q == ST_CLEAR) && !stage.fire)
    else $error("tag wrap without clearing pass");

endmodule

>>> tb/sv/masked_probability_argmax_top_tb.sv
// ----------------------------------------------------------------------------
// masked_probability_argmax_top_tb
// self-checking bench for the masked histogram argmax block: directed runs
// for the corner cases, then random runs under changing subset masks, with an
// in-bench model predicting the winner of every run
// ----------------------------------------------------------------------------
module masked_probability_argmax_top_tb;
  import mpa_pkg::*;

  localparam int unsigned NumQubits  = NumQubitsDef;
  localparam int unsigned FracBits   = FracBitsDef;
  localparam int unsigned StoreDepth = 1 << NumQubits;
  localparam int unsigned ProbW      = FracBits + 1;  // unsigned q1.frac
  localparam int unsigned SumW       = FracBits + 2;  // unsigned q2.frac
  localparam int unsigned InTdataW   = ((NumQubits + ProbW + 7) / 8) * 8;
  localparam int unsigned OutTdataW  = ((NumQubits + SumW + 7) / 8) * 8;

  // register map
  localparam logic [PaddrW-1:0] SubsetMaskAddr = '0;

  // DrainCycles covers a beat still in flight in the read and update stages
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomBeats = 850;

  typedef logic [NumQubits-1:0] state_t;
  typedef logic [ProbW-1:0]     prob_t;
  typedef logic [SumW-1:0]      sum_t;

  typedef struct packed {
    logic   last;
    prob_t  prob;
    state_t index;
  } beat_t;

  typedef struct packed {
    sum_t   prob;
    state_t state;
  } winner_t;

  localparam prob_t ProbOne   = prob_t'(1) << FracBits;
  localparam prob_t ProbHalf  = ProbOne >> 1;
  localparam prob_t Prob3Qtr  = ProbOne - (ProbOne >> 2);
  localparam prob_t ProbMax   = '1;

  // --------------------------------------------------------------------------
  // clock, reset and block ports; every input known from time zero
  // --------------------------------------------------------------------------
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;  // basis_index, probability
  logic                 s_axis_tlast  = 1'b0;  // last_item
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;  // best_state, best_probability
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [PaddrW-1:0]    paddr         = '0;
  logic [PdataW-1:0]    pwdata        = '0;
  logic [PdataW-1:0]    prdata;
  logic                 pready;

  always #5 clk_i = ~clk_i;

  masked_probability_argmax_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  beat_t       beats_to_send[$];   // filled by the sequence, drained by the driver
  winner_t     winners_due[$];     // predicted result of every closed run
  sum_t        state_sums[StoreDepth];
  state_t      leader_state;
  sum_t        leader_sum;
  state_t      mask_model;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  logic        beat_taken     = 1'b0;
  beat_t       next_beat;
  winner_t     oldest_winner;
  state_t      got_state;
  sum_t        got_prob;

  int unsigned error_count    = 0;
  int unsigned beats_queued   = 0;
  int unsigned runs_checked   = 0;
  int unsigned saturated_runs = 0;
  int unsigned mask_writes    = 0;

  // --------------------------------------------------------------------------
  // predictor: add the beat into its masked bin with saturation, track the
  // strictly largest bin (the bin that led first wins a tie), close the run on last
  // --------------------------------------------------------------------------
  function automatic void tally_beat(state_t index, prob_t prob, logic last);
    state_t        bin;
    logic [SumW:0] raw;
    sum_t          total;
    bin   = index & mask_model;
    raw   = state_sums[bin] + prob;
    total = raw[SumW] ? '1 : raw[SumW-1:0];
    state_sums[bin] = total;
    if (total > leader_sum) begin
      leader_state = bin;
      leader_sum   = total;
    end
    if (last) begin
      winners_due.push_back('{prob: leader_sum, state: leader_state});
      foreach (state_sums[i]) state_sums[i] = '0;
      leader_state = '0;
      leader_sum   = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // driver: new beat or idle at the falling edge, only once the current beat
  // went through; tready toggles at random on the result side
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || beat_taken)) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_beat = beats_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= InTdataW'({next_beat.prob, next_beat.index});
        s_axis_tlast  <= next_beat.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // monitor: results checked before the beat of the same edge is predicted;
  // a register write lands after the beat, though the two never coincide
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    beat_taken = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_state = m_axis_tdata[NumQubits-1:0];
        got_prob  = m_axis_tdata[NumQubits+SumW-1:NumQubits];
        if (winners_due.size() == 0) begin
          $error("result beat with no run closed: best_state %0d best_probability 0x%0h",
                 got_state, got_prob);
          error_count++;
        end else begin
          oldest_winner = winners_due.pop_front();
          runs_checked++;
          if (oldest_winner.prob == '1) saturated_runs++;
          if (got_state !== oldest_winner.state) begin
            $error("best_state: expected %0d, actual %0d", oldest_winner.state, got_state);
            error_count++;
          end
          if (got_prob !== oldest_winner.prob) begin
            $error("best_probability: expected 0x%0h, actual 0x%0h",
                   oldest_winner.prob, got_prob);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beat_taken = 1'b1;
        tally_beat(s_axis_tdata[NumQubits-1:0], s_axis_tdata[NumQubits+ProbW-1:NumQubits],
                   s_axis_tlast);
      end
      if (psel && penable && pwrite && pready && paddr == SubsetMaskAddr) begin
        mask_model = pwdata[NumQubits-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence helpers
  // --------------------------------------------------------------------------
  task automatic push_beat(state_t index, prob_t prob, logic last);
    beats_to_send.push_back('{last: last, prob: prob, index: index});
    beats_queued++;
  endtask

  // sender empty, every result in, then DrainCycles more for a beat still in the pipe
  task automatic wait_drained();
    do @(posedge clk_i);
    while (beats_to_send.size() != 0 || s_axis_tvalid || winners_due.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // apb write of the subset mask while the block is quiet, then read it back
  task automatic write_mask(state_t value);
    logic [PdataW-1:0] readback;
    wait_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SubsetMaskAddr;
    pwdata  <= PdataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    if (readback !== PdataW'(value)) begin
      $error("subset_mask: expected 0x%0h, actual 0x%0h", value, readback);
      error_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    mask_writes++;
  endtask

  // probabilities lean on the edges: zero, one, all ones, quarter steps for ties
  function automatic prob_t random_prob();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ProbOne;
      2:       return ProbMax;
      3, 4:    return prob_t'({$urandom(), $urandom()});
      5:       return prob_t'($urandom_range(4096));
      6, 7:    return prob_t'($urandom_range(4, 1)) << (FracBits - 2);
      default: return prob_t'($urandom()) >> $urandom_range(12);
    endcase
  endfunction

  function automatic state_t random_mask();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return state_t'(1) << $urandom_range(NumQubits - 1);
      3:       return state_t'($urandom()) & state_t'($urandom()) & state_t'($urandom());
      default: return state_t'($urandom());
    endcase
  endfunction

  // a run is mostly short, sometimes long; now and then the mask moves mid-run
  task automatic push_run();
    int unsigned run_len;
    int unsigned split_at;
    case ($urandom_range(19))
      0:       run_len = $urandom_range(80, 31);
      1, 2, 3: run_len = $urandom_range(30, 7);
      default: run_len = $urandom_range(6, 1);
    endcase
    split_at = ($urandom_range(19) == 0) ? $urandom_range(run_len - 1) : run_len;
    for (int unsigned i = 0; i < run_len; i++) begin
      if (i == split_at && i != 0) write_mask(random_mask());
      push_beat(state_t'($urandom()), random_prob(), i == run_len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_end;
    foreach (state_sums[i]) state_sums[i] = '0;
    leader_state = '0;
    leader_sum   = '0;
    mask_model   = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_gap_pct   = 24;
    recv_stall_pct = 79;

    // reset mask of zero folds every index into state zero
    push_beat(10'h3FF, ProbMax, 1'b0);
    push_beat(10'h005, ProbOne, 1'b1);

    // full mask, a run of zero probabilities reports state zero with zero
    write_mask('1);
    push_beat(10'h155, '0, 1'b0);
    push_beat(10'h2AA, '0, 1'b1);

    // three maximal probabilities into one state saturate its sum
    push_beat(10'h3FF, ProbMax, 1'b0);
    push_beat(10'h3FF, ProbMax, 1'b0);
    push_beat(10'h3FF, ProbMax, 1'b0);
    push_beat(10'h000, ProbOne, 1'b1);

    // tie: the state that got there first keeps the lead
    push_beat(10'h003, ProbOne, 1'b0);
    push_beat(10'h007, ProbOne, 1'b0);
    push_beat(10'h009, '0, 1'b1);

    // a later state overtakes once its sum is strictly larger
    push_beat(10'h007, ProbHalf, 1'b0);
    push_beat(10'h002, Prob3Qtr, 1'b0);
    push_beat(10'h007, ProbHalf, 1'b1);

    // single-beat run
    push_beat(10'h2AA, ProbOne, 1'b1);

    // mask narrowed mid-run, the sum built so far stays
    push_beat(10'h005, ProbHalf, 1'b0);
    write_mask(10'h00F);
    push_beat(10'h3F5, Prob3Qtr, 1'b1);

    // single top bit kept, lower index bits dropped
    write_mask(10'h200);
    push_beat(10'h1FF, Prob3Qtr, 1'b0);
    push_beat(10'h3FF, ProbHalf, 1'b0);
    push_beat(10'h3FF, ProbHalf, 1'b1);

    // random runs in three idle profiles
    write_mask('0);
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      send_gap_pct   = (phase == 0) ? 24 : (phase == 1) ? 79 : 0;
      recv_stall_pct = (phase == 0) ? 79 : (phase == 1) ? 24 : 0;
      phase_end      = beats_queued + RandomBeats / 3;
      if (phase == 1) write_mask('1);
      while (beats_queued < phase_end) begin
        if ($urandom_range(7) == 0) write_mask(random_mask());
        push_run();
      end
    end

    wait_drained();
    $display("%0d beats over %0d runs checked, %0d mask writes, %0d runs saturated",
             beats_queued, runs_checked, mask_writes, saturated_runs);
    $display("idle profiles: sender-light, receiver-light, back-to-back");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run including clearing passes
  initial begin
    #(4_000_000);
    $error("timeout with %0d beats unsent and %0d results outstanding",
           beats_to_send.size(), winners_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
rtl/mpa_pkg.sv
rtl/mpa_acc_mem.sv
rtl/mpa_update.sv
rtl/mpa_out_buf.sv
rtl/masked_probability_argmax_top.sv
tb/sv/masked_probability_argmax_top_tb.sv
